// File: sv/voxel_column_grid_store_macros.svh
// Assertion macros used by the request sequencer of the voxel column grid store RTL.
`ifndef VOXEL_COLUMN_GRID_STORE_MACROS_SVH
`define VOXEL_COLUMN_GRID_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VCGS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VCGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/vcgs_pkg.sv
// Shared constants, types and helper functions of the voxel column grid store.
package vcgs_pkg;

   localparam int GRID_WIDTH  = 16;
   localparam int GRID_HEIGHT = 16;
   localparam int GRID_DEPTH  = 16;
   localparam int TILE_BITS   = 8;

   localparam int PLANE      = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_COUNT = PLANE * GRID_DEPTH;
   localparam int ADDR_BITS  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // Fixed widths of the beat fields.
   localparam int COORD_BITS   = 4;
   localparam int TILE_FLD     = 8;
   localparam int SURF_BITS    = 5;
   localparam int RUN_NUM_BITS = 3;

   localparam int MAX_RUNS  = 8;
   localparam int CNT_BITS  = $clog2(MAX_RUNS + 1);
   localparam int ZCNT_BITS = $clog2(GRID_DEPTH + 1);

   localparam logic signed [SURF_BITS-1:0] SURF_NONE = -5'sd1;
   localparam logic [COORD_BITS-1:0] LAST_LVL = COORD_BITS'(GRID_DEPTH - 1);

   typedef logic [TILE_BITS-1:0]  tile_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COORD_BITS-1:0] coord_type;

   typedef enum logic [2:0] {
      MODE_READ    = 3'd0,
      MODE_WRITE   = 3'd1,
      MODE_SURFACE = 3'd2,
      MODE_EMPTY   = 3'd3,
      MODE_FILLED  = 3'd4,
      MODE_CLEAR   = 3'd5
   } mode_type;

   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      addr_type addr;
      tile_type wdata;
   } mem_req_type;

   typedef struct packed {
      mode_type            mode;
      coord_type           coord_x;
      coord_type           coord_y;
      coord_type           coord_z;
      logic [TILE_FLD-1:0] tile_in;
   } req_type;

   typedef struct packed {
      logic [TILE_FLD-1:0]         tile_out;
      logic signed [SURF_BITS-1:0] surface_level;
      logic                        range_valid;
      coord_type                   range_start;
      coord_type                   range_end;
      logic [RUN_NUM_BITS-1:0]     range_number;
      logic                        last;
   } res_type;

   function automatic logic col_in_grid(coord_type x, coord_type y);
      return (32'(x) < GRID_WIDTH) && (32'(y) < GRID_HEIGHT);
   endfunction

   function automatic addr_type cell_addr(coord_type x, coord_type y, coord_type z);
      return ADDR_BITS'(32'(z) * PLANE + 32'(y) * GRID_WIDTH + 32'(x));
   endfunction

endpackage

// File: sv/vcgs_cell_mem.sv
// Single-port cell memory with a registered, enabled read.
module vcgs_cell_mem (
   input  logic                   clock,
   input  vcgs_pkg::mem_req_type  mreq,
   output vcgs_pkg::tile_type     rd_data
);

   vcgs_pkg::tile_type mem_array [vcgs_pkg::CELL_COUNT];
   vcgs_pkg::tile_type rd_data_ff;

   // The read register only loads when a read is issued, so a stalled scan keeps its data.
   always_ff @(posedge clock) begin
      if (mreq.wr_en) begin
         mem_array[mreq.addr] <= mreq.wdata;
      end
      if (mreq.rd_en) begin
         rd_data_ff <= mem_array[mreq.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/vcgs_out_reg.sv
// Result output register that decouples the sequencer from the response channel.
module vcgs_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vcgs_pkg::res_type res,
   output logic              out_free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output vcgs_pkg::res_type rsp_res
);

   logic              valid_ff;
   logic              valid_in;
   vcgs_pkg::res_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = push || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

// File: sv/vcgs_ctrl.sv
// Request sequencer: clearing sweeps, cell access and pipelined column scans.
`include "voxel_column_grid_store_macros.svh"

module vcgs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vcgs_pkg::req_type      req,
   input  logic [7:0]             empty_code,
   output vcgs_pkg::mem_req_type  mreq,
   input  vcgs_pkg::tile_type     rd_data,
   input  logic                   out_free,
   output logic                   push,
   output vcgs_pkg::res_type      res
);

   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   vcgs_pkg::addr_type sweep_ff, sweep_in;
   vcgs_pkg::tile_type fill_ff, fill_in;
   vcgs_pkg::mode_type mode_ff, mode_in;
   vcgs_pkg::coord_type x_ff, x_in, y_ff, y_in;
   logic loc_ok_ff, loc_ok_in;
   logic [vcgs_pkg::ZCNT_BITS-1:0] z_issue_ff, z_issue_in;
   logic eval_valid_ff, eval_valid_in;
   vcgs_pkg::coord_type z_eval_ff, z_eval_in;
   logic open_ff, open_in;
   vcgs_pkg::coord_type start_ff, start_in;
   logic [vcgs_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic signed [vcgs_pkg::SURF_BITS-1:0] surf_ff, surf_in;
   logic pend_valid_ff, pend_valid_in;
   vcgs_pkg::res_type pend_ff, pend_in;

   vcgs_pkg::tile_type  empty_val;
   vcgs_pkg::coord_type start_cur;
   vcgs_pkg::coord_type gen_start;
   vcgs_pkg::coord_type gen_end;
   logic accept, filled, match, is_range, last_cell, gen, stall, done;
   logic in_scan_fin;
   logic count_ok;

   assign empty_val = vcgs_pkg::TILE_BITS'(empty_code);
   assign accept    = req_valid && req_ready;
   assign filled    = loc_ok_ff && (rd_data != empty_val);
   assign match     = (filled == (mode_ff == vcgs_pkg::MODE_FILLED));
   assign is_range  = (mode_ff == vcgs_pkg::MODE_EMPTY) || (mode_ff == vcgs_pkg::MODE_FILLED);
   assign last_cell = (z_eval_ff == vcgs_pkg::LAST_LVL);
   assign start_cur = open_ff ? start_ff : z_eval_ff;

   // A run closes when the level that ends it is evaluated, or at the top of the column.
   always_comb begin
      gen       = 1'b0;
      gen_start = start_cur;
      gen_end   = vcgs_pkg::LAST_LVL;
      if (eval_valid_ff && is_range) begin
         if (match) begin
            gen = last_cell;
         end else if (open_ff) begin
            gen       = 1'b1;
            gen_start = start_ff;
            gen_end   = z_eval_ff - 1'b1;
         end
      end
   end

   assign stall = (state_ff == ST_SCAN) && gen && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      fill_in       = fill_ff;
      mode_in       = mode_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      loc_ok_in     = loc_ok_ff;
      z_issue_in    = z_issue_ff;
      eval_valid_in = eval_valid_ff;
      z_eval_in     = z_eval_ff;
      open_in       = open_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      surf_in       = surf_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      mreq          = '0;
      push          = 1'b0;
      res           = '0;
      done          = 1'b0;
      req_ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_SWEEP: begin
            mreq.wr_en = 1'b1;
            mreq.addr  = sweep_ff;
            mreq.wdata = fill_ff;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == vcgs_pkg::ADDR_BITS'(vcgs_pkg::CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req.mode;
               x_in      = req.coord_x;
               y_in      = req.coord_y;
               loc_ok_in = vcgs_pkg::col_in_grid(req.coord_x, req.coord_y);
               case (req.mode) inside
                  vcgs_pkg::MODE_READ: begin
                     loc_ok_in  = vcgs_pkg::col_in_grid(req.coord_x, req.coord_y) &&
                                  (32'(req.coord_z) < vcgs_pkg::GRID_DEPTH);
                     mreq.rd_en = 1'b1;
                     mreq.addr  = vcgs_pkg::cell_addr(req.coord_x, req.coord_y, req.coord_z);
                     state_in   = ST_FIN;
                  end
                  vcgs_pkg::MODE_WRITE: begin
                     mreq.wr_en = vcgs_pkg::col_in_grid(req.coord_x, req.coord_y) &&
                                  (32'(req.coord_z) < vcgs_pkg::GRID_DEPTH);
                     mreq.addr  = vcgs_pkg::cell_addr(req.coord_x, req.coord_y, req.coord_z);
                     mreq.wdata = vcgs_pkg::TILE_BITS'(req.tile_in);
                  end
                  vcgs_pkg::MODE_SURFACE, vcgs_pkg::MODE_EMPTY, vcgs_pkg::MODE_FILLED: begin
                     z_issue_in    = '0;
                     eval_valid_in = 1'b0;
                     open_in       = 1'b0;
                     count_in      = '0;
                     surf_in       = vcgs_pkg::SURF_NONE;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  vcgs_pkg::MODE_CLEAR: begin
                     fill_in  = empty_val;
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (eval_valid_ff) begin
                  if (filled) begin
                     surf_in = $signed({1'b0, z_eval_ff});
                  end
                  open_in  = match;
                  start_in = start_cur;
                  if (gen) begin
                     count_in = count_ff + 1'b1;
                     if (pend_valid_ff) begin
                        push = 1'b1;
                        res  = pend_ff;
                     end
                     pend_in              = '0;
                     pend_in.range_valid  = 1'b1;
                     pend_in.range_start  = gen_start;
                     pend_in.range_end    = gen_end;
                     pend_in.range_number = vcgs_pkg::RUN_NUM_BITS'(count_ff);
                     pend_valid_in        = 1'b1;
                  end
                  done = last_cell ||
                         (gen && (count_ff == vcgs_pkg::CNT_BITS'(vcgs_pkg::MAX_RUNS - 1)));
               end
               if (!done && (z_issue_ff != vcgs_pkg::ZCNT_BITS'(vcgs_pkg::GRID_DEPTH))) begin
                  mreq.rd_en    = 1'b1;
                  mreq.addr     = vcgs_pkg::cell_addr(x_ff, y_ff,
                                     vcgs_pkg::COORD_BITS'(z_issue_ff));
                  z_issue_in    = z_issue_ff + 1'b1;
                  eval_valid_in = 1'b1;
                  z_eval_in     = vcgs_pkg::COORD_BITS'(z_issue_ff);
               end else begin
                  eval_valid_in = 1'b0;
               end
               if (done) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               push = 1'b1;
               case (mode_ff)
                  vcgs_pkg::MODE_READ: begin
                     res.tile_out = vcgs_pkg::TILE_FLD'(loc_ok_ff ? rd_data : empty_val);
                  end
                  vcgs_pkg::MODE_SURFACE: begin
                     res.surface_level = surf_ff;
                  end
                  default: begin
                     if (pend_valid_ff) begin
                        res = pend_ff;
                     end
                  end
               endcase
               res.last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         fill_ff       <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         open_ff       <= 1'b0;
         count_ff      <= '0;
         z_issue_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         fill_ff       <= fill_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         open_ff       <= open_in;
         count_ff      <= count_in;
         z_issue_ff    <= z_issue_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      loc_ok_ff <= loc_ok_in;
      z_eval_ff <= z_eval_in;
      start_ff  <= start_in;
      surf_ff   <= surf_in;
      pend_ff   <= pend_in;
   end

   assign in_scan_fin = (state_ff == ST_SCAN) || (state_ff == ST_FIN);
   assign count_ok    = (count_ff <= vcgs_pkg::CNT_BITS'(vcgs_pkg::MAX_RUNS));

   `VCGS_ASSERT_HOLDS(a_port_excl, clock, reset, mreq.rd_en, !mreq.wr_en, "read with write")
   `VCGS_ASSERT_HOLDS(a_push_free, clock, reset, push, out_free, "push into full register")
   `VCGS_ASSERT_NEXT(a_stall_hold, clock, reset, stall, $stable({z_issue_ff, pend_ff}), "scan moved")
   `VCGS_ASSERT_HOLDS(a_pend_state, clock, reset, pend_valid_ff, in_scan_fin, "stray run")
   `VCGS_ASSERT_HOLDS(a_count_max, clock, reset, 1'b1, count_ok, "run count overflow")

endmodule

// File: sv/voxel_column_grid_store.sv
// Top level of the voxel column grid store: ports, configuration register and wiring.
//
//   Channel  Direction  Handshake               Contents
//   req      in         req_tvalid/req_tready   request beat: coordinates, tile, mode in tuser
//   rsp      out        rsp_tvalid/rsp_tready   result beat: tile, surface, run, last in tlast
//   csr      in         csr_valid/csr_ready     empty code write, always ready
//
// Surface and the run modes scan the column bottom up, reading one cell per cycle through
// the single memory port unless a full result register stalls the scan; a run scan stops
// early after MAX_RUNS runs, and the final result is handed over from the finishing state.
// Clear sweeps all GRID_WIDTH * GRID_HEIGHT * GRID_DEPTH (4096) cells, one per cycle.
// After reset the same sweep zeroes the memory with req_tready low.
// A full result register stalls the scan in place; the next request beat is taken while
// the final result of the previous one still waits on the response channel.
module voxel_column_grid_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] coord_x, [7:4] coord_y, [11:8] coord_z, [19:12] tile_in, [23:20] zero
   input  logic [23:0] req_tdata,
   // [2:0] mode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tile_out, [12:8] surface_level, [16:13] range_start, [20:17] range_end,
   // [23:21] range_number
   output logic [23:0] rsp_tdata,
   // [0] range_valid
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0] empty_code_ff;
   logic [7:0] empty_code_in;

   vcgs_pkg::req_type     req;
   vcgs_pkg::mem_req_type mreq;
   vcgs_pkg::tile_type    rd_data;
   vcgs_pkg::res_type     res;
   vcgs_pkg::res_type     rsp_res;
   logic                  push;
   logic                  out_free;

   // The empty code register takes a write in any cycle.
   assign csr_ready     = 1'b1;
   assign empty_code_in = (csr_valid && csr_ready) ? csr_data : empty_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_code_ff <= '0;
      end else begin
         empty_code_ff <= empty_code_in;
      end
   end

   // Unpack the request beat.
   assign req.mode    = vcgs_pkg::mode_type'(req_tuser);
   assign req.coord_x = req_tdata[3:0];
   assign req.coord_y = req_tdata[7:4];
   assign req.coord_z = req_tdata[11:8];
   assign req.tile_in = req_tdata[19:12];

   vcgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .empty_code (empty_code_ff),
      .mreq       (mreq),
      .rd_data    (rd_data),
      .out_free   (out_free),
      .push       (push),
      .res        (res)
   );

   vcgs_cell_mem u_mem (
      .clock   (clock),
      .mreq    (mreq),
      .rd_data (rd_data)
   );

   vcgs_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   // Pack the result beat.
   assign rsp_tdata = {rsp_res.range_number, rsp_res.range_end, rsp_res.range_start,
                       rsp_res.surface_level, rsp_res.tile_out};
   assign rsp_tuser = rsp_res.range_valid;
   assign rsp_tlast = rsp_res.last;

endmodule

// File: sim/voxel_column_grid_store_tb.sv
// Self-checking testbench of the voxel column grid store with a shadow grid.
module voxel_column_grid_store_tb;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SETTLE       = 4200;  // a clear sweep may still run after the last result
   localparam int DRAIN_CYCLES = 4200;
   localparam int HOLD_CYCLES  = 400;
   localparam int DIR_ROWS     = 26;
   localparam int REPORT_MAX   = 10;

   // The two spare mode codes are accepted and ignored by the block.
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] z;
      logic [7:0] tile;
   } col_req_type;

   typedef struct packed {
      col_req_type       beat;
      logic              typed;
      vcgs_pkg::res_type want;
   } dir_row_type;

   // Results that can be read off at a glance.
   localparam vcgs_pkg::res_type RD_ZERO   = '{8'h00, 5'h00, 1'b0, 4'd0, 4'd0, 3'd0, 1'b1};
   localparam vcgs_pkg::res_type RD_FULL   = '{8'hFF, 5'h00, 1'b0, 4'd0, 4'd0, 3'd0, 1'b1};
   localparam vcgs_pkg::res_type SURF_NIL  = '{8'h00, 5'h1F, 1'b0, 4'd0, 4'd0, 3'd0, 1'b1};
   localparam vcgs_pkg::res_type SURF_TOP  = '{8'h00, 5'd15, 1'b0, 4'd0, 4'd0, 3'd0, 1'b1};
   localparam vcgs_pkg::res_type RUN_WHOLE = '{8'h00, 5'h00, 1'b1, 4'd0, 4'd15, 3'd0, 1'b1};
   localparam vcgs_pkg::res_type RUN_NONE  = '{8'h00, 5'h00, 1'b0, 4'd0, 4'd0, 3'd0, 1'b1};
   localparam vcgs_pkg::res_type NO_RES    = '0;

   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{'{vcgs_pkg::MODE_READ,    4'd0,  4'd0,  4'd0,  8'h00}, 1'b1, RD_ZERO},
      '{'{vcgs_pkg::MODE_READ,    4'd15, 4'd15, 4'd15, 8'h00}, 1'b1, RD_ZERO},
      '{'{vcgs_pkg::MODE_SURFACE, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b1, SURF_NIL},
      '{'{vcgs_pkg::MODE_EMPTY,   4'd3,  4'd4,  4'd0,  8'h00}, 1'b1, RUN_WHOLE},
      '{'{vcgs_pkg::MODE_FILLED,  4'd3,  4'd4,  4'd0,  8'h00}, 1'b1, RUN_NONE},
      '{'{vcgs_pkg::MODE_WRITE,   4'd15, 4'd15, 4'd15, 8'hFF}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_READ,    4'd15, 4'd15, 4'd15, 8'h00}, 1'b1, RD_FULL},
      '{'{vcgs_pkg::MODE_SURFACE, 4'd15, 4'd15, 4'd0,  8'h00}, 1'b1, SURF_TOP},
      '{'{vcgs_pkg::MODE_WRITE,   4'd15, 4'd15, 4'd0,  8'hA5}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_FILLED,  4'd15, 4'd15, 4'd0,  8'h00}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_EMPTY,   4'd15, 4'd15, 4'd0,  8'h00}, 1'b0, NO_RES},
      // Alternating column at (0,0): eight filled and eight empty runs.
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd0,  8'h01}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd2,  8'h80}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd4,  8'h7F}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd6,  8'hFE}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd8,  8'h55}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd10, 8'hAA}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd12, 8'h0F}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_WRITE,   4'd0,  4'd0,  4'd14, 8'hF0}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_FILLED,  4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_EMPTY,   4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, NO_RES},
      '{'{MODE_SPARE_6,           4'd15, 4'd15, 4'd15, 8'hFF}, 1'b0, NO_RES},
      '{'{MODE_SPARE_7,           4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_READ,    4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_CLEAR,   4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, NO_RES},
      '{'{vcgs_pkg::MODE_SURFACE, 4'd15, 4'd15, 4'd0,  8'h00}, 1'b1, SURF_NIL}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   // Shadow copy of the grid and the empty code register.
   logic [7:0]        shadow_cells [vcgs_pkg::CELL_COUNT];
   logic [7:0]        shadow_empty;
   vcgs_pkg::res_type pending_results [$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // Long receiver hold-off, started by a toggle from the stimulus process.
   logic hold_go   = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   voxel_column_grid_store u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   function automatic int cell_index(input logic [3:0] x, input logic [3:0] y,
                                     input logic [3:0] z);
      return int'(z) * vcgs_pkg::PLANE + int'(y) * vcgs_pkg::GRID_WIDTH + int'(x);
   endfunction

   // Appends one expected result beat to the scoreboard queue.
   function automatic void add_expected(input vcgs_pkg::res_type r);
      pending_results = {pending_results, r};
   endfunction

   // Scans the column bottom up and queues one result per maximal run, up to MAX_RUNS, or RUN_NONE if there is none.
   function automatic void queue_runs(input logic [3:0] x, input logic [3:0] y,
                                      input bit want_filled);
      vcgs_pkg::res_type runs [vcgs_pkg::MAX_RUNS];
      int                count;
      bit                open;
      bit                filled;
      int                start;
      count = 0;
      open  = 1'b0;
      start = 0;
      for (int z = 0; z < vcgs_pkg::GRID_DEPTH && count < vcgs_pkg::MAX_RUNS; z++) begin
         filled = shadow_cells[cell_index(x, y, 4'(z))] != shadow_empty;
         if (filled == want_filled) begin
            if (!open) begin
               open  = 1'b1;
               start = z;
            end
         end else if (open) begin
            runs[count] = '{8'h00, 5'h00, 1'b1, 4'(start), 4'(z - 1), 3'(count), 1'b0};
            count++;
            open = 1'b0;
         end
      end
      if (open && count < vcgs_pkg::MAX_RUNS) begin
         runs[count] = '{8'h00, 5'h00, 1'b1, 4'(start), 4'(vcgs_pkg::GRID_DEPTH - 1),
                         3'(count), 1'b0};
         count++;
      end
      if (count == 0) begin
         add_expected(RUN_NONE);
      end else begin
         runs[count - 1].last = 1'b1;
         for (int k = 0; k < count; k++) add_expected(runs[k]);
      end
   endfunction

   // Applies one accepted request to the shadow state; queues its results when emit is set.
   function automatic void model_request(input col_req_type r, input bit emit);
      vcgs_pkg::res_type res;
      int                lvl;
      res      = '0;
      res.last = 1'b1;
      case (r.mode)
         vcgs_pkg::MODE_READ: begin
            res.tile_out = shadow_cells[cell_index(r.x, r.y, r.z)];
            if (emit) add_expected(res);
         end
         vcgs_pkg::MODE_WRITE: shadow_cells[cell_index(r.x, r.y, r.z)] = r.tile;
         vcgs_pkg::MODE_SURFACE: begin
            lvl = vcgs_pkg::GRID_DEPTH - 1;
            while (lvl >= 0 && shadow_cells[cell_index(r.x, r.y, 4'(lvl))] == shadow_empty)
               lvl--;
            res.surface_level = 5'(lvl);
            if (emit) add_expected(res);
         end
         vcgs_pkg::MODE_EMPTY:  if (emit) queue_runs(r.x, r.y, 1'b0);
         vcgs_pkg::MODE_FILLED: if (emit) queue_runs(r.x, r.y, 1'b1);
         vcgs_pkg::MODE_CLEAR:  foreach (shadow_cells[i]) shadow_cells[i] = shadow_empty;
         default: ;
      endcase
   endfunction

   // Offers one request beat after an optional idle gap and returns at the accepting edge.
   task automatic send_beat(input col_req_type r);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, r.tile, r.z, r.y, r.x};
      req_tuser  <= r.mode;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes the empty code once the block has gone quiet.
   task automatic program_empty_code(input logic [7:0] code);
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      shadow_empty  = code;
   endtask

   // Random requests aimed mostly at a few hot columns so that runs build up.
   task automatic send_random_items(input int count);
      col_req_type r;
      int          sent;
      int          pick;
      bit          hot;
      sent = 0;
      while (sent < count) begin
         pick   = $urandom_range(99);
         hot    = $urandom_range(99) < 70;
         r.x    = hot ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
         r.y    = hot ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 15));
         r.z    = 4'($urandom_range(0, 15));
         r.tile = ($urandom_range(1) != 0) ? shadow_empty : 8'($urandom_range(0, 255));
         if (pick < 40)      r.mode = vcgs_pkg::MODE_WRITE;
         else if (pick < 52) r.mode = vcgs_pkg::MODE_READ;
         else if (pick < 62) r.mode = vcgs_pkg::MODE_SURFACE;
         else if (pick < 74) r.mode = vcgs_pkg::MODE_EMPTY;
         else if (pick < 86) r.mode = vcgs_pkg::MODE_FILLED;
         else if (pick < 88) r.mode = vcgs_pkg::MODE_CLEAR;
         else if (pick < 94) r.mode = MODE_SPARE_6;
         else                r.mode = MODE_SPARE_7;
         send_beat(r);
         model_request(r, 1'b1);
         if (r.mode <= vcgs_pkg::MODE_CLEAR) sent++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen  <= hold_go;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   always @(posedge clock) begin : check_results
      vcgs_pkg::res_type got;
      vcgs_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[12:8], rsp_tuser, rsp_tdata[16:13],
                 rsp_tdata[20:17], rsp_tdata[23:21], rsp_tlast};
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected: tile=%0d surf=%0d valid=%0d run=%0d..%0d #%0d last=%0d",
                        got.tile_out, got.surface_level, got.range_valid, got.range_start,
                        got.range_end, got.range_number, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got.tile_out != want.tile_out || got.surface_level != want.surface_level ||
                got.range_valid != want.range_valid || got.range_start != want.range_start ||
                got.range_end != want.range_end || got.range_number != want.range_number ||
                got.last != want.last) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("mismatch: want tile=%0d surf=%0d valid=%0d run=%0d..%0d #%0d last=%0d",
                           want.tile_out, want.surface_level, want.range_valid,
                           want.range_start, want.range_end, want.range_number, want.last);
                  $display("          got  tile=%0d surf=%0d valid=%0d run=%0d..%0d #%0d last=%0d",
                           got.tile_out, got.surface_level, got.range_valid,
                           got.range_start, got.range_end, got.range_number, got.last);
               end
            end
         end
      end
   end

   initial begin
      col_req_type r;
      foreach (shadow_cells[i]) shadow_cells[i] = 8'h00;
      shadow_empty = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table with the reset empty code; the block first sweeps its memory.
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_beat(DIRECTED[i].beat);
         model_request(DIRECTED[i].beat, !DIRECTED[i].typed);
         if (DIRECTED[i].typed) add_expected(DIRECTED[i].want);
      end

      program_empty_code(8'hFF);
      send_random_items(28);

      program_empty_code(8'($urandom_range(1, 254)));
      req_idle_pct = 80;
      send_random_items(28);

      program_empty_code(8'h00);
      req_idle_pct  = 0;
      rsp_stall_pct = 80;
      send_random_items(14);
      wait_for_results();
      send_random_items(14);

      program_empty_code(8'($urandom_range(1, 254)));
      req_idle_pct  = 23;
      rsp_stall_pct = 23;
      send_random_items(28);

      // Receiver holds off while reads keep coming, so the block backs up its input.
      program_empty_code(8'($urandom_range(0, 255)));
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_go <= ~hold_go;
      for (int i = 0; i < 10; i++) begin
         r = '{vcgs_pkg::MODE_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)), 8'h00};
         send_beat(r);
         model_request(r, 1'b1);
      end
      send_random_items(16);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
